FILE: rtl/core/pift_pkg.sv
// shared types and constants for the point in figure tester
`default_nettype none
package pift_pkg;
    localparam int unsigned KIND_WIDTH = 2;
    localparam int unsigned PNUM_WIDTH = 16;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_RECT   = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_TRI    = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC1,
        ST_CALC2,
        ST_DECIDE,
        ST_EMIT,
        ST_NONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_point;
        logic write_fig;
        logic read_fig;
        logic calc1;
        logic calc2;
        logic decide;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
    } dp_sts_t;
endpackage
`default_nettype wire

FILE: rtl/core/pift_datapath.sv
// figure store and containment arithmetic
`default_nettype none
module pift_datapath #(
    parameter int unsigned MAX_FIGURES = 16,
    parameter int unsigned COORD_WIDTH = 24,
    parameter int unsigned IDX_WIDTH   = 4
) (
    input  wire logic                         aclk,
    input  wire pift_pkg::dp_cmd_t            cmd,
    input  wire logic [IDX_WIDTH-1:0]         wr_idx,
    input  wire logic [IDX_WIDTH-1:0]         rd_idx,
    input  wire logic [pift_pkg::KIND_WIDTH-1:0] in_kind,
    input  wire logic signed [COORD_WIDTH-1:0] in_a,
    input  wire logic signed [COORD_WIDTH-1:0] in_b,
    input  wire logic signed [COORD_WIDTH-1:0] in_c,
    input  wire logic signed [COORD_WIDTH-1:0] in_d,
    input  wire logic signed [COORD_WIDTH-1:0] in_e,
    input  wire logic signed [COORD_WIDTH-1:0] in_f,
    output pift_pkg::dp_sts_t                 sts
);
    import pift_pkg::*;

    localparam int unsigned DW = COORD_WIDTH + 2;     // differences
    localparam int unsigned PW = 2 * DW;              // products
    localparam int unsigned SW = PW + 3;              // sums
    localparam int unsigned ENTRY_W = KIND_WIDTH + 6 * COORD_WIDTH;

    logic [ENTRY_W-1:0] fig_mem [MAX_FIGURES];
    logic [ENTRY_W-1:0] entry_reg;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;

    logic signed [COORD_WIDTH-1:0] ca, cb, cc, cd, ce, cf;
    logic [KIND_WIDTH-1:0] ekind;

    logic signed [DW-1:0] d [6];
    logic signed [PW-1:0] p_reg [8];
    logic signed [PW-1:0] p_next [8];
    logic signed [SW-1:0] s_reg [4];
    logic signed [SW-1:0] s_next [4];
    logic rect_reg, rect_next;
    logic hit_reg, hit_next;

    assign ekind = entry_reg[ENTRY_W-1 -: KIND_WIDTH];
    assign ca = entry_reg[0*COORD_WIDTH +: COORD_WIDTH];
    assign cb = entry_reg[1*COORD_WIDTH +: COORD_WIDTH];
    assign cc = entry_reg[2*COORD_WIDTH +: COORD_WIDTH];
    assign cd = entry_reg[3*COORD_WIDTH +: COORD_WIDTH];
    assign ce = entry_reg[4*COORD_WIDTH +: COORD_WIDTH];
    assign cf = entry_reg[5*COORD_WIDTH +: COORD_WIDTH];

    function automatic logic signed [DW-1:0] sub(input logic signed [COORD_WIDTH-1:0] a,
                                                  input logic signed [COORD_WIDTH-1:0] b);
        return DW'(a) - DW'(b);
    endfunction

    function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] v);
        return v[SW-1] ? -v : v;
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.write_fig) begin
            fig_mem[wr_idx] <= {in_kind, in_f, in_e, in_d, in_c, in_b, in_a};
        end
        if (cmd.read_fig) begin
            entry_reg <= fig_mem[rd_idx];
        end
    end

    // difference operands; up to eight products per figure (three for a circle)
    always_comb begin
        for (int i = 0; i < 6; i++) d[i] = '0;
        if (ekind == KIND_CIRCLE) begin
            d[0] = sub(ca, px_reg); d[1] = sub(ca, px_reg);
            d[2] = sub(cb, py_reg); d[3] = sub(cb, py_reg);
            d[4] = DW'(cc);         d[5] = DW'(cc);
        end else begin
            // whole: (x2-x1)(y3-y1) - (x3-x1)(y2-y1)
            d[0] = sub(cc, ca); d[1] = sub(cf, cb);
            d[2] = sub(ce, ca); d[3] = sub(cd, cb);
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) p_next[i] = p_reg[i];
        for (int i = 0; i < 4; i++) s_next[i] = s_reg[i];
        rect_next = rect_reg;
        hit_next  = hit_reg;
        if (cmd.calc1) begin
            rect_next = (px_reg > ca) && (px_reg < cc) && (py_reg < cb) && (py_reg > cd);
            if (ekind == KIND_CIRCLE) begin
                p_next[0] = PW'(d[0]) * PW'(d[1]);
                p_next[1] = PW'(d[2]) * PW'(d[3]);
                p_next[2] = PW'(d[4]) * PW'(d[5]);
                p_next[3] = '0;
                p_next[4] = '0; p_next[5] = '0; p_next[6] = '0; p_next[7] = '0;
            end else begin
                p_next[0] = PW'(d[0]) * PW'(d[1]);
                p_next[1] = PW'(d[2]) * PW'(d[3]);
                p_next[2] = PW'(sub(cc, ca)) * PW'(sub(py_reg, cb));
                p_next[3] = PW'(sub(px_reg, ca)) * PW'(sub(cd, cb));
                p_next[4] = PW'(sub(ce, cc)) * PW'(sub(py_reg, cd));
                p_next[5] = PW'(sub(px_reg, cc)) * PW'(sub(cf, cd));
                p_next[6] = PW'(sub(ca, ce)) * PW'(sub(py_reg, cf));
                p_next[7] = PW'(sub(px_reg, ce)) * PW'(sub(cb, cf));
            end
        end
        if (cmd.calc2) begin
            if (ekind == KIND_CIRCLE) begin
                s_next[0] = SW'(p_reg[0]) + SW'(p_reg[1]);
                s_next[1] = SW'(p_reg[2]);
                s_next[2] = '0;
                s_next[3] = '0;
            end else begin
                s_next[0] = sabs(SW'(p_reg[0]) - SW'(p_reg[1]));
                s_next[1] = sabs(SW'(p_reg[2]) - SW'(p_reg[3]));
                s_next[2] = sabs(SW'(p_reg[4]) - SW'(p_reg[5]));
                s_next[3] = sabs(SW'(p_reg[6]) - SW'(p_reg[7]));
            end
        end
        if (cmd.decide) begin
            unique case (kind_t'(ekind))
                KIND_RECT:   hit_next = rect_reg;
                KIND_CIRCLE: hit_next = (cc > 0) && (s_reg[0] < s_reg[1]);
                KIND_TRI:    hit_next = (s_reg[1] != '0) && (s_reg[2] != '0)
                                        && (s_reg[3] != '0)
                                        && (s_reg[1] + s_reg[2] + s_reg[3] == s_reg[0]);
                default:     hit_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            px_reg <= in_a;
            py_reg <= in_b;
        end
        p_reg    <= p_next;
        s_reg    <= s_next;
        rect_reg <= rect_next;
        hit_reg  <= hit_next;
    end

    assign sts.hit = hit_reg;
endmodule
`default_nettype wire

FILE: rtl/core/pift_ctrl.sv
// sequencer over the figure table for add and query transactions
`default_nettype none
module pift_ctrl #(
    parameter int unsigned MAX_FIGURES = 16,
    parameter int unsigned IDX_WIDTH   = 4,
    parameter int unsigned CNT_WIDTH   = 5,
    parameter int unsigned FNUM_WIDTH  = 5
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       in_op,
    input  wire logic [pift_pkg::KIND_WIDTH-1:0] in_kind,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [pift_pkg::PNUM_WIDTH-1:0] out_pnum,
    output logic [FNUM_WIDTH-1:0]           out_fnum,
    output logic                            out_contained,
    output logic                            out_last,
    output pift_pkg::dp_cmd_t               cmd,
    input  wire pift_pkg::dp_sts_t          sts,
    output logic [IDX_WIDTH-1:0]            wr_idx,
    output logic [IDX_WIDTH-1:0]            rd_idx
);
    import pift_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_WIDTH-1:0] count_reg, count_next;
    logic [CNT_WIDTH-1:0] idx_reg, idx_next;
    logic [PNUM_WIDTH-1:0] pnum_reg, pnum_next;
    logic any_reg, any_next;
    logic ov_reg, ov_next;
    logic [FNUM_WIDTH-1:0] fnum_reg, fnum_next;
    logic cont_reg, cont_next, last_reg, last_next;
    logic out_fire;
    logic out_free;
    logic more;

    assign out_fire = out_valid && out_ready;
    assign out_free = !ov_reg || out_fire;
    assign more     = (idx_reg + 1'b1) < count_reg;
    assign wr_idx   = count_reg[IDX_WIDTH-1:0];
    assign rd_idx   = idx_reg[IDX_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pnum_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pnum_reg  <= pnum_next;
            ov_reg    <= ov_next;
        end
        idx_reg  <= idx_next;
        any_reg  <= any_next;
        fnum_reg <= fnum_next;
        cont_reg <= cont_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pnum_next  = pnum_reg;
        any_next   = any_reg;
        ov_next    = ov_reg && !out_fire;
        fnum_next  = fnum_reg;
        cont_next  = cont_reg;
        last_next  = last_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // wait for the result register to drain so the point number stays put
                in_ready = !ov_reg;
                if (in_valid && !ov_reg) begin
                    if (in_op == OP_ADD) begin
                        if (in_kind != KIND_NONE && count_reg < CNT_WIDTH'(MAX_FIGURES)) begin
                            cmd.write_fig = 1'b1;
                            count_next    = count_reg + 1'b1;
                        end
                    end else begin
                        cmd.load_point = 1'b1;
                        pnum_next      = pnum_reg + 1'b1;
                        idx_next       = '0;
                        any_next       = 1'b0;
                        state_next     = (count_reg == '0) ? ST_NONE : ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.read_fig = 1'b1;
                state_next   = ST_CALC1;
            end
            ST_CALC1: begin
                cmd.calc1  = 1'b1;
                state_next = ST_CALC2;
            end
            ST_CALC2: begin
                cmd.calc2  = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.hit) begin
                    if (more) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end else if (!any_reg) begin
                        state_next = ST_NONE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (out_free) begin
                    ov_next   = 1'b1;
                    fnum_next = FNUM_WIDTH'(idx_reg) + 1'b1;
                    cont_next = 1'b1;
                    last_next = 1'b0;
                    any_next  = 1'b1;
                    if (more) begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    fnum_next  = '0;
                    cont_next  = 1'b0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // the last hit is flagged by peeking ahead: a held hit goes out when the next hit
    // is found (not last) or when the walk ends (last)
    assign out_valid     = ov_reg && (!cont_reg || state_reg == ST_IDLE
                                      || (state_reg == ST_EMIT && sts.hit));
    assign out_pnum      = pnum_reg;
    assign out_fnum      = fnum_reg;
    assign out_contained = cont_reg;
    assign out_last      = last_reg || (cont_reg && state_reg == ST_IDLE);
endmodule
`default_nettype wire

FILE: rtl/core/point_in_figure_tester.sv
// top level of the point in figure tester
//
// channel  dir  fields (tdata low to high / tuser)
// s_axis   in   tdata: figure_kind, coord_a..coord_f (pad to 152 bits); tuser: opcode
// m_axis   out  tdata: point_number, figure_number, contained (pad to 24); tlast: last
//
// a query walks each stored figure through the table read, product, sum, compare and result
// steps of the datapath; an empty table gives a single not-contained result
// a hit result is held until the next hit or the end of the walk so last can be set
// reset clears the figure count and the point counter; the table is not cleared
// a waiting result stalls the walk at the next hit and holds s_axis_tready low when idle
`default_nettype none
module point_in_figure_tester #(
    parameter int unsigned MAX_FIGURES = 16,
    parameter int unsigned COORD_WIDTH = 24
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // figure_kind, coord_a, coord_b, coord_c, coord_d, coord_e, coord_f, zero pad
    input  wire logic [((2 + 6 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // opcode
    input  wire logic s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // point_number, figure_number, contained, zero pad
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    import pift_pkg::*;

    localparam int unsigned IDX_WIDTH  = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int unsigned CNT_WIDTH  = $clog2(MAX_FIGURES + 1);
    localparam int unsigned FNUM_WIDTH = 5;

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic [IDX_WIDTH-1:0] wr_idx, rd_idx;
    logic [PNUM_WIDTH-1:0] pnum;
    logic [FNUM_WIDTH-1:0] fnum;
    logic contained;

    // tdata fields
    logic [KIND_WIDTH-1:0] kind;
    assign kind = s_axis_tdata[KIND_WIDTH-1:0];

    pift_ctrl #(
        .MAX_FIGURES(MAX_FIGURES),
        .IDX_WIDTH  (IDX_WIDTH),
        .CNT_WIDTH  (CNT_WIDTH),
        .FNUM_WIDTH (FNUM_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_op        (s_axis_tuser),
        .in_kind      (kind),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_pnum     (pnum),
        .out_fnum     (fnum),
        .out_contained(contained),
        .out_last     (m_axis_tlast),
        .cmd          (cmd),
        .sts          (sts),
        .wr_idx       (wr_idx),
        .rd_idx       (rd_idx)
    );

    pift_datapath #(
        .MAX_FIGURES(MAX_FIGURES),
        .COORD_WIDTH(COORD_WIDTH),
        .IDX_WIDTH  (IDX_WIDTH)
    ) u_dp (
        .aclk   (aclk),
        .cmd    (cmd),
        .wr_idx (wr_idx),
        .rd_idx (rd_idx),
        .in_kind(kind),
        .in_a   (s_axis_tdata[KIND_WIDTH + 0*COORD_WIDTH +: COORD_WIDTH]),
        .in_b   (s_axis_tdata[KIND_WIDTH + 1*COORD_WIDTH +: COORD_WIDTH]),
        .in_c   (s_axis_tdata[KIND_WIDTH + 2*COORD_WIDTH +: COORD_WIDTH]),
        .in_d   (s_axis_tdata[KIND_WIDTH + 3*COORD_WIDTH +: COORD_WIDTH]),
        .in_e   (s_axis_tdata[KIND_WIDTH + 4*COORD_WIDTH +: COORD_WIDTH]),
        .in_f   (s_axis_tdata[KIND_WIDTH + 5*COORD_WIDTH +: COORD_WIDTH]),
        .sts    (sts)
    );

    assign m_axis_tdata = {2'b00, contained, fnum, pnum};
endmodule
`default_nettype wire
